FILE: rtl/ties_sign_elect_topk_merge_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sign-elect top-k merge block
// Property wrappers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TIES_SIGN_ELECT_TOPK_MERGE_DEFINES_SVH
`define TIES_SIGN_ELECT_TOPK_MERGE_DEFINES_SVH
`ifndef SYNTHESIS
`define TSETM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TSETM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSETM_ASSERT_SAME(lbl, ante, cons, msg)
`define TSETM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/tsetm_pkg.sv
// ----------------------------------------------------------------------------
// tsetm_pkg
// Shared constants, controller states and command/status types.
// ----------------------------------------------------------------------------
`default_nettype none
package tsetm_pkg;
  localparam int unsigned Dim        = 64;
  localparam int unsigned MaxTensors = 16;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned ValW       = 24;
  localparam int unsigned SumW       = 28;
  localparam int unsigned TallyW     = 6;
  localparam int unsigned CntW       = 5;
  localparam int unsigned EcW        = 7;
  localparam int unsigned DensW      = 17;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegElementCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDensityFraction = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_RD_I, S_LAT_I, S_RD_J, S_CMP_J, S_DIV, S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load_rd;
    logic load_wr;
    logic i_rd;
    logic i_latch;
    logic j_rd;
    logic j_cmp;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic j_last;
    logic div_last;
    logic i_last;
  } sts_t;
endpackage
`default_nettype wire

FILE: rtl/tsetm_ctrl.sv
// ----------------------------------------------------------------------------
// tsetm_ctrl
// Sequencer for loading, ranking, division and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
module tsetm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  tsetm_pkg::sts_t     sts_i,
  output tsetm_pkg::cmd_t     cmd_o,
  output logic                busy_o
);
  import tsetm_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_i) state_d = S_LOAD;
      S_LOAD:  state_d = sts_i.fin ? S_RD_I : S_IDLE;
      S_RD_I:  state_d = S_LAT_I;
      S_LAT_I: state_d = S_RD_J;
      S_RD_J:  state_d = S_CMP_J;
      S_CMP_J: state_d = sts_i.j_last ? S_DIV : S_RD_J;
      S_DIV:   state_d = sts_i.div_last ? S_EMIT : S_DIV;
      S_EMIT:  state_d = sts_i.i_last ? S_IDLE : S_RD_I;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.load_rd = start_i;
      end
      S_LOAD:  cmd_o.load_wr  = 1'b1;
      S_RD_I:  cmd_o.i_rd     = 1'b1;
      S_LAT_I: cmd_o.i_latch  = 1'b1;
      S_RD_J:  cmd_o.j_rd     = 1'b1;
      S_CMP_J: cmd_o.j_cmp    = 1'b1;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_EMIT:  cmd_o.emit     = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/tsetm_dp.sv
// ----------------------------------------------------------------------------
// tsetm_dp
// Per-position tally and sum stores, rank counter, serial divider, outputs.
// ----------------------------------------------------------------------------
`default_nettype none
module tsetm_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tsetm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tsetm_pkg::DensW-1:0]    cfg_wdata_i,
  input  wire logic signed [tsetm_pkg::ValW-1:0] value_i,
  input  wire logic                           final_item_i,
  input  tsetm_pkg::cmd_t                     cmd_i,
  output tsetm_pkg::sts_t                     sts_o,
  output logic                                valid_o,
  output logic signed [tsetm_pkg::ValW-1:0]   merged_value_o,
  output logic [tsetm_pkg::IdxW-1:0]          position_o,
  output logic                                last_o,
  output logic                                overflow_o
);
  import tsetm_pkg::*;

  logic [EcW-1:0]   ec_cfg_q;
  logic [DensW-1:0] dens_cfg_q;
  logic [EcW-1:0]   ec;
  logic [DensW-1:0] dens;
  logic [23:0]      keep_prod;
  logic [EcW-1:0]   keep;

  logic [SumW-1:0]   pos_mem [Dim];
  logic [SumW-1:0]   neg_mem [Dim];
  logic [TallyW-1:0] tly_mem [Dim];
  logic [Dim-1:0]    vld_q;

  logic [IdxW-1:0] elem_pos_q;
  logic [CntW-1:0] tcount_q;
  logic            ovf_q;
  logic [EcW-1:0]  pos_inc;

  logic signed [ValW-1:0] val_q;
  logic            fin_q, acc_q;
  logic [IdxW-1:0] p_q;
  logic [CntW-1:0] run_q;

  logic [IdxW-1:0]   addr_a;
  logic              rd_a_en;
  logic [SumW-1:0]   pa_pos_q, pa_neg_q, pb_pos_q, pb_neg_q;
  logic [TallyW-1:0] pa_tly_q;
  logic              pa_vld_q, pb_vld_q;
  logic [SumW-1:0]   pa_pos, pa_neg, pb_pos, pb_neg;
  logic [TallyW-1:0] pa_tly;
  logic [ValW-1:0]   mag;

  logic [IdxW-1:0] i_q, j_q;
  logic [SumW:0]   mi_q, mj;
  logic [EcW-1:0]  better_q;
  logic            neg_sel_q;
  logic            sel_pos;

  logic [SumW-1:0] quo_q;
  logic [CntW-1:0] rem_q;
  logic [CntW-1:0] dcnt_q;
  logic [CntW:0]   rem_sh;
  logic            qbit;
  logic [ValW-1:0] res;

  logic                   out_vld_q, out_last_q, out_ovf_q;
  logic signed [ValW-1:0] out_val_q;
  logic [IdxW-1:0]        out_pos_q;

  always_comb begin
    ec   = (ec_cfg_q == '0 || ec_cfg_q > EcW'(Dim)) ? EcW'(Dim) : ec_cfg_q;
    dens = (dens_cfg_q > 17'd65536) ? 17'd65536 : dens_cfg_q;
    keep_prod = 24'(ec) * 24'(dens);
    keep = keep_prod[22:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_cfg_q   <= EcW'(Dim);
      dens_cfg_q <= 17'd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegElementCount:    ec_cfg_q   <= cfg_wdata_i[EcW-1:0];
        RegDensityFraction: dens_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign pos_inc = {1'b0, elem_pos_q} + EcW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_pos_q <= '0;
      tcount_q   <= '0;
      ovf_q      <= 1'b0;
      vld_q      <= '0;
      i_q        <= '0;
    end else begin
      if (cmd_i.load_rd) begin
        if (tcount_q >= CntW'(MaxTensors)) begin
          ovf_q <= 1'b1;
        end
        if (pos_inc >= ec) begin
          elem_pos_q <= '0;
          if (tcount_q < CntW'(MaxTensors)) begin
            tcount_q <= tcount_q + CntW'(1);
          end
        end else begin
          elem_pos_q <= pos_inc[IdxW-1:0];
        end
      end
      if (cmd_i.load_wr && acc_q) begin
        vld_q[p_q] <= 1'b1;
      end
      if (cmd_i.emit) begin
        i_q <= i_q + IdxW'(1);
        if (sts_o.i_last) begin
          elem_pos_q <= '0;
          tcount_q   <= '0;
          ovf_q      <= 1'b0;
          vld_q      <= '0;
          i_q        <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rd) begin
      val_q <= value_i;
      fin_q <= final_item_i;
      p_q   <= elem_pos_q;
      acc_q <= tcount_q < CntW'(MaxTensors);
      run_q <= (tcount_q < CntW'(MaxTensors)) ? tcount_q + CntW'(1) : CntW'(MaxTensors);
    end
  end

  assign addr_a  = cmd_i.load_rd ? elem_pos_q : i_q;
  assign rd_a_en = cmd_i.load_rd | cmd_i.i_rd;
  assign mag     = ~val_q + ValW'(1);

  always_ff @(posedge clk_i) begin
    if (rd_a_en) begin
      pa_pos_q <= pos_mem[addr_a];
      pa_neg_q <= neg_mem[addr_a];
      pa_tly_q <= tly_mem[addr_a];
      pa_vld_q <= vld_q[addr_a];
    end
    if (cmd_i.j_rd) begin
      pb_pos_q <= pos_mem[j_q];
      pb_neg_q <= neg_mem[j_q];
      pb_vld_q <= vld_q[j_q];
    end
    if (cmd_i.load_wr && acc_q) begin
      if (val_q > 0) begin
        pos_mem[p_q] <= pa_pos + SumW'(val_q);
        tly_mem[p_q] <= pa_tly + TallyW'(1);
        neg_mem[p_q] <= pa_neg;
      end else if (val_q < 0) begin
        pos_mem[p_q] <= pa_pos;
        tly_mem[p_q] <= pa_tly;
        neg_mem[p_q] <= pa_neg + SumW'(mag);
      end else begin
        pos_mem[p_q] <= pa_pos;
        tly_mem[p_q] <= pa_tly;
        neg_mem[p_q] <= pa_neg;
      end
    end
  end

  assign pa_pos = pa_vld_q ? pa_pos_q : '0;
  assign pa_neg = pa_vld_q ? pa_neg_q : '0;
  assign pa_tly = pa_vld_q ? pa_tly_q : '0;
  assign pb_pos = pb_vld_q ? pb_pos_q : '0;
  assign pb_neg = pb_vld_q ? pb_neg_q : '0;
  assign mj     = {1'b0, pb_pos} + {1'b0, pb_neg};
  assign sel_pos = {1'b0, pa_tly, 1'b0} > (TallyW+2)'(run_q);

  assign rem_sh = {rem_q, quo_q[SumW-1]};
  assign qbit   = rem_sh >= {1'b0, run_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else if (cmd_i.i_latch) begin
      j_q <= '0;
    end else if (cmd_i.j_cmp) begin
      j_q <= j_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.i_latch) begin
      mi_q      <= {1'b0, pa_pos} + {1'b0, pa_neg};
      neg_sel_q <= ~sel_pos;
      quo_q     <= sel_pos ? pa_pos : pa_neg;
      rem_q     <= '0;
      dcnt_q    <= '0;
      better_q  <= '0;
    end
    if (cmd_i.j_cmp && (mj > mi_q || (mj == mi_q && j_q > i_q))) begin
      better_q <= better_q + EcW'(1);
    end
    if (cmd_i.div_step) begin
      quo_q  <= {quo_q[SumW-2:0], qbit};
      rem_q  <= qbit ? CntW'(rem_sh - {1'b0, run_q}) : rem_sh[CntW-1:0];
      dcnt_q <= dcnt_q + CntW'(1);
    end
  end

  always_comb begin
    sts_o.fin      = fin_q;
    sts_o.j_last   = ({1'b0, j_q} + EcW'(1)) == ec;
    sts_o.div_last = dcnt_q == CntW'(SumW - 1);
    sts_o.i_last   = ({1'b0, i_q} + EcW'(1)) == ec;
  end

  always_comb begin
    if (better_q < keep) begin
      res = neg_sel_q ? (~quo_q[ValW-1:0] + ValW'(1)) : quo_q[ValW-1:0];
    end else begin
      res = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_val_q  <= res;
      out_pos_q  <= i_q;
      out_last_q <= sts_o.i_last;
      out_ovf_q  <= ovf_q;
    end
  end

  assign valid_o        = out_vld_q;
  assign merged_value_o = out_val_q;
  assign position_o     = out_pos_q;
  assign last_o         = out_last_q;
  assign overflow_o     = out_ovf_q;
endmodule
`default_nettype wire

FILE: rtl/ties_sign_elect_topk_merge.sv
// Each input item is read, then the write back of its position follows.
// After the final item each position is read and latched in turn:
// the rank scan reads each position once, a 28-step divider follows, then emit.
// One result strobe per position; the receiver cannot stall.
// Reset clears the valid bits (old sums read as zero) and load/scan counters, restores the config.
// ----------------------------------------------------------------------------
// ties_sign_elect_topk_merge
// Sign-elected top-k merge of streamed tensors, top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ties_sign_elect_topk_merge_defines.svh"
module ties_sign_elect_topk_merge (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tsetm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [tsetm_pkg::DensW-1:0]       cfg_wdata_i,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic signed [tsetm_pkg::ValW-1:0] value_i,
  input  wire logic                              final_item_i,
  output logic                                   valid_o,
  output logic signed [tsetm_pkg::ValW-1:0]      merged_value_o,
  output logic [tsetm_pkg::IdxW-1:0]             position_o,
  output logic                                   last_o,
  output logic                                   overflow_o
);
  import tsetm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tsetm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  tsetm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .value_i        (value_i),
    .final_item_i   (final_item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .valid_o        (valid_o),
    .merged_value_o (merged_value_o),
    .position_o     (position_o),
    .last_o         (last_o),
    .overflow_o     (overflow_o)
  );

  `TSETM_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted item not worked on")
  `TSETM_ASSERT_SAME(a_valid_busy, valid_o, $past(busy_o), "result without a run")
  `TSETM_ASSERT_NEXT(a_last_ends, valid_o && last_o, !valid_o, "result after the final one")
endmodule
`default_nettype wire
